### src/sto_pkg.sv
// sto_pkg: shared types, constants and elaboration-time tables for the sine tone oscillator
// no dependencies; imported by every module of the block

package sto_pkg;

	// default parameter values
	localparam int PHASE_BITS_DEF     = 32;
	localparam int SINE_ADDR_BITS_DEF = 10;
	localparam int SAMPLE_BITS_DEF    = 16;

	// field widths
	localparam int NF_W       = 16;
	localparam int AMP_W      = 16;
	localparam int NOTE_W     = 7;
	localparam int FREQ_W     = 23;
	localparam int HZ_W       = 36;
	localparam int HZ_LO_W    = 18;
	localparam int HZ_HI_W    = HZ_W - HZ_LO_W;
	localparam int IN_TDATA_W = 40;

	// hz_to_step reset value, floor(2^48 / 48000)
	localparam logic [HZ_W-1:0] HZ_STEP_RESET = 36'd5864062014;

	// control mapping: freq_q8 = ((nf * 22499 + 128) >> 8) + 256
	localparam int FREQ_SPAN  = 22499;
	localparam int FREQ_ROUND = 128;
	localparam int FREQ_FRAC  = 8;
	localparam int FREQ_BASE  = 256;
	localparam int SCALED_W   = 31;

	// pitch table
	localparam int NOTE_COUNT  = 128;
	localparam int SEMITONES   = 12;
	localparam int NOTE_OFFSET = 3;
	localparam int A4_HZ       = 440;
	localparam int PITCH_SHIFT = 14;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Q30 fixed point for the sine series
	localparam int Q30_BITS = 30;

	typedef logic [FREQ_W-1:0] freq_t;
	typedef freq_t pitch_rom_t [NOTE_COUNT];

	// one request handed from front to back
	typedef struct packed {
		freq_t            freq;
		logic [AMP_W-1:0] amplitude;
	} sto_item_t;

	// back-end sequencer states
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LOOK,
		BK_READ,
		BK_SCALE,
		BK_EMIT
	} back_state_t;

	// 2^(k/12) in Q16
	localparam logic [16:0] SEMITONE_Q16 [SEMITONES] = '{
		17'd65536, 17'd69433, 17'd73562, 17'd77936, 17'd82570, 17'd87480,
		17'd92682, 17'd98193, 17'd104032, 17'd110218, 17'd116772, 17'd123715
	};

	// odd series coefficients of sin(pi/2 * x), Q30
	localparam logic [63:0] SIN_C0 = 64'd1686629713;
	localparam logic [63:0] SIN_C1 = 64'd693598669;
	localparam logic [63:0] SIN_C2 = 64'd85569306;
	localparam logic [63:0] SIN_C3 = 64'd5026994;
	localparam logic [63:0] SIN_C4 = 64'd172272;

	// equal-tempered frequency of every note, Q8 Hz
	function automatic pitch_rom_t build_pitch();
		pitch_rom_t  rom;
		int          d;
		int          oct;
		int          k;
		logic [63:0] x;
		for (int n = 0; n < NOTE_COUNT; n++) begin
			d = n + NOTE_OFFSET;
			oct = d / SEMITONES;
			k = d % SEMITONES;
			x = (64'(A4_HZ) * 64'(SEMITONE_Q16[k])) << oct;
			x = (x + (64'd1 << (PITCH_SHIFT - 1))) >> PITCH_SHIFT;
			rom[n] = x[FREQ_W-1:0];
		end
		return rom;
	endfunction

	localparam pitch_rom_t PITCH_ROM = build_pitch();

	// quarter-wave entry i for a table of 2^a_bits steps and s_bits-bit samples
	function automatic logic [63:0] sine_entry(int i, int a_bits, int s_bits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] full;
		x = 64'(i) << (Q30_BITS - a_bits);
		x2 = (x * x) >> Q30_BITS;
		t = SIN_C4;
		t = SIN_C3 - ((x2 * t) >> Q30_BITS);
		t = SIN_C2 - ((x2 * t) >> Q30_BITS);
		t = SIN_C1 - ((x2 * t) >> Q30_BITS);
		t = SIN_C0 - ((x2 * t) >> Q30_BITS);
		s = (x * t) >> Q30_BITS;
		if (s > (64'd1 << Q30_BITS)) begin
			s = 64'd1 << Q30_BITS;
		end
		full = (64'd1 << (s_bits - 1)) - 64'd1;
		return (s * full + (64'd1 << (Q30_BITS - 1))) >> Q30_BITS;
	endfunction

endpackage

### src/sto_front.sv
// sto_front: accepts sample requests, tracks the note override and forms the frequency
// depends on sto_pkg; feeds sto_queue

module sto_front
	import sto_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [NF_W-1:0]  norm_frequency,
	input  logic [AMP_W-1:0] amplitude,
	input  logic             note_on,
	input  logic [NOTE_W-1:0] note_pitch,
	input  logic             full,
	output logic             push,
	output sto_item_t        item
);

	logic              active_q;
	logic [NOTE_W-1:0] note_q;
	logic              eff_active;
	logic [NOTE_W-1:0] eff_note;
	logic [SCALED_W-1:0] scaled;
	freq_t             freq_ctrl;

	// a request is taken whenever the queue has room
	assign s_tready = !full;
	assign push     = s_tvalid && s_tready;

	// a note-on takes effect on its own sample
	assign eff_active = note_on || active_q;
	assign eff_note   = note_on ? note_pitch : note_q;

	// linear map of the control onto 1 Hz .. just under 22500 Hz
	assign scaled    = SCALED_W'(norm_frequency) * SCALED_W'(FREQ_SPAN) + SCALED_W'(FREQ_ROUND);
	assign freq_ctrl = FREQ_W'(scaled >> FREQ_FRAC) + FREQ_W'(FREQ_BASE);

	assign item.freq      = eff_active ? PITCH_ROM[eff_note] : freq_ctrl;
	assign item.amplitude = amplitude;

	// override latch, never cleared once set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			note_q   <= '0;
		end else if (push && note_on) begin
			active_q <= 1'b1;
			note_q   <= note_pitch;
		end
	end

endmodule

### src/sto_queue.sv
// sto_queue: short register queue between the front and the back of the oscillator
// depends on sto_pkg

module sto_queue
	import sto_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  sto_item_t item_in,
	output logic      full,
	input  logic      pop,
	output sto_item_t item_out,
	output logic      empty
);

	localparam int DEPTH = QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sto_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign item_out = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count above depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow a push");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count did not follow a pop");

endmodule

### src/sto_back.sv
// sto_back: phase accumulator, quarter-wave lookup, gain and output register
// depends on sto_pkg; drains sto_queue and drives the result channel

module sto_back
	import sto_pkg::*;
#(
	parameter int PHASE_BITS     = PHASE_BITS_DEF,
	parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF,
	parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [HZ_W-1:0]        hz_to_step,
	input  sto_item_t              item_in,
	input  logic                   empty,
	output logic                   pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [SAMPLE_BITS-1:0] sample_out
);

	localparam int IDX_W      = SINE_ADDR_BITS + 1;
	localparam int SINE_DEPTH = (1 << SINE_ADDR_BITS) + 1;
	localparam int WORD_W     = SAMPLE_BITS - 1;
	localparam int HALF_PROD_W = FREQ_W + HZ_HI_W;
	localparam int PROD_W     = FREQ_W + HZ_W;
	localparam int STEP_SHIFT = 56 - PHASE_BITS;
	localparam int MULT_W     = AMP_W + WORD_W;
	localparam logic [IDX_W-1:0] IDX_FULL = IDX_W'(1) << SINE_ADDR_BITS;

	typedef logic [WORD_W-1:0] sine_word_t;
	typedef sine_word_t sine_rom_t [SINE_DEPTH];

	// quarter-wave table, filled at elaboration
	function automatic sine_rom_t build_sine();
		sine_rom_t rom;
		for (int i = 0; i < SINE_DEPTH; i++) begin
			rom[i] = sine_word_t'(sine_entry(i, SINE_ADDR_BITS, SAMPLE_BITS));
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine();

	back_state_t             state_q;
	back_state_t             state_d;
	logic [PHASE_BITS-1:0]   phase_q;
	logic                    out_valid_q;
	logic [SAMPLE_BITS-1:0]  out_data_q;

	sto_item_t               item_q;
	logic [1:0]              quad_q;
	logic [IDX_W-1:0]        idx_q;
	logic [HALF_PROD_W-1:0]  prod_lo_q;
	logic [HALF_PROD_W-1:0]  prod_hi_q;
	sine_word_t              sine_q;
	logic [MULT_W-1:0]       mult_q;

	logic                    out_free;
	logic                    load_out;
	logic [HZ_HI_W-1:0]      mul_b;
	logic [HALF_PROD_W-1:0]  mul_p;
	logic [1:0]              quad_d;
	logic [SINE_ADDR_BITS-1:0] raw_idx;
	logic [IDX_W-1:0]        idx_d;
	logic [PROD_W-1:0]       prod_sum;
	logic [PHASE_BITS-1:0]   step;
	logic [MULT_W:0]         rounded;
	logic [SAMPLE_BITS-1:0]  mag;
	logic [SAMPLE_BITS-1:0]  val;

	assign out_free = !out_valid_q || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE:  if (!empty) state_d = BK_LOOK;
			BK_LOOK:  state_d = BK_READ;
			BK_READ:  state_d = BK_SCALE;
			BK_SCALE: state_d = BK_EMIT;
			BK_EMIT: begin
				if (out_free) begin
					state_d = empty ? BK_IDLE : BK_LOOK;
				end
			end
			default:  state_d = BK_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		pop      = 1'b0;
		load_out = 1'b0;
		mul_b    = hz_to_step[HZ_W-1:HZ_LO_W];
		case (state_q)
			BK_IDLE: pop = !empty;
			BK_LOOK: mul_b = HZ_HI_W'(hz_to_step[HZ_LO_W-1:0]);
			BK_EMIT: begin
				load_out = out_free;
				pop      = out_free && !empty;
			end
			default: ;
		endcase
	end

	// shared step multiplier, low half then high half of hz_to_step
	assign mul_p = HALF_PROD_W'(item_q.freq) * HALF_PROD_W'(mul_b);

	// quadrant fold of the current phase
	assign quad_d  = phase_q[PHASE_BITS-1 -: 2];
	assign raw_idx = phase_q[PHASE_BITS-3 -: SINE_ADDR_BITS];
	assign idx_d   = quad_d[0] ? (IDX_FULL - {1'b0, raw_idx}) : {1'b0, raw_idx};

	// phase step from the two partial products
	assign prod_sum = (PROD_W'(prod_hi_q) << HZ_LO_W) + PROD_W'(prod_lo_q);
	assign step     = prod_sum[STEP_SHIFT +: PHASE_BITS];

	// rounding and sign of the scaled sample
	assign rounded = {1'b0, mult_q} + (MULT_W + 1)'(1 << (AMP_W - 1));
	assign mag     = rounded[MULT_W -: SAMPLE_BITS];
	assign val     = quad_q[1] ? (SAMPLE_BITS'(0) - mag) : mag;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_SCALE) begin
				phase_q <= phase_q + step;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= item_in;
		end
		if (state_q == BK_LOOK) begin
			quad_q    <= quad_d;
			idx_q     <= idx_d;
			prod_lo_q <= mul_p;
		end
		if (state_q == BK_READ) begin
			sine_q    <= SINE_ROM[idx_q];
			prod_hi_q <= mul_p;
		end
		if (state_q == BK_SCALE) begin
			mult_q <= MULT_W'(item_q.amplitude) * MULT_W'(sine_q);
		end
		if (load_out) begin
			out_data_q <= val;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign sample_out = out_data_q;

	// checks
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from an empty queue");

	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != BK_SCALE) |=> phase_q == $past(phase_q))
		else $error("phase moved outside the update step");

	a_emit_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_EMIT && out_valid_q && !m_tready) |=> state_q == BK_EMIT)
		else $error("result dropped while the receiver stalls");

endmodule

### src/sine_tone_oscillator_unit.sv
// sine_tone_oscillator_unit: direct digital synthesis sine oscillator, top level
// depends on sto_pkg, sto_front, sto_queue and sto_back
//
// usage
//   s_* channel: one request per audio sample carrying the frequency control,
//   the gain and an optional note-on; every request yields exactly one sample
//   on the m_* channel, in order.
//   cfg_we / cfg_wdata write hz_to_step = round(2^48 / sample_rate); write it
//   only while no request is in flight.
//   the front takes a request in the cycle it is offered as long as the
//   two-entry queue has room, so requests are taken while results wait.
//   the back sequencer takes each sample through LOOK (fold the phase, low
//   partial product of the step), READ (quarter-wave table, high partial
//   product), SCALE (gain, phase advance) and EMIT (load the output register);
//   one shared step multiplier and the registered table read set these steps.
//   the back works on one sample at a time and waits in EMIT while m_tready
//   stalls; an idle back pops a request in IDLE, and m_tvalid rises after EMIT.
//   reset clears the phase, the note override and the queue and sets
//   hz_to_step to its 48 kHz value. when m_tready is low the output register
//   holds its sample, the back waits and the queue fills; s_tready then falls.

module sine_tone_oscillator_unit
	import sto_pkg::*;
#(
	parameter int PHASE_BITS     = PHASE_BITS_DEF,
	parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF,
	parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
	localparam int OUT_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_we,
	input  logic [HZ_W-1:0]        cfg_wdata,
	// sample requests
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // norm_frequency[15:0], amplitude[31:16], note_pitch[38:32]
	input  logic                   s_tuser,  // note_on
	// generated samples
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata   // sample_out[SAMPLE_BITS-1:0]
);

	logic [HZ_W-1:0]        hz_to_step_q;
	logic                   push;
	logic                   pop;
	logic                   full;
	logic                   empty;
	sto_item_t              front_item;
	sto_item_t              queue_item;
	logic [SAMPLE_BITS-1:0] sample_out;

	// frequency-to-step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hz_to_step_q <= HZ_STEP_RESET;
		end else if (cfg_we) begin
			hz_to_step_q <= cfg_wdata;
		end
	end

	// request intake and frequency selection
	sto_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.norm_frequency (s_tdata[NF_W-1:0]),
		.amplitude      (s_tdata[NF_W +: AMP_W]),
		.note_on        (s_tuser),
		.note_pitch     (s_tdata[NF_W + AMP_W +: NOTE_W]),
		.full           (full),
		.push           (push),
		.item           (front_item)
	);

	// decoupling queue
	sto_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item_in  (front_item),
		.full     (full),
		.pop      (pop),
		.item_out (queue_item),
		.empty    (empty)
	);

	// synthesis back end
	sto_back #(
		.PHASE_BITS     (PHASE_BITS),
		.SINE_ADDR_BITS (SINE_ADDR_BITS),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.hz_to_step (hz_to_step_q),
		.item_in    (queue_item),
		.empty      (empty),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.sample_out (sample_out)
	);

	assign m_tdata = OUT_TDATA_W'(sample_out);

endmodule
